### src/tnc_pkg.sv
// Package for the tagged number conversion core.
// Holds kind codes, shared constants and inter-stage structs. No dependencies.
package tnc_pkg;

	typedef enum logic [1:0] {
		KIND_I32 = 2'd0,
		KIND_I64 = 2'd1,
		KIND_F64 = 2'd2,
		KIND_UNS = 2'd3
	} kind_t;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned EXP_W  = 11;
	localparam int unsigned MANT_W = 52;
	localparam int unsigned BIAS   = 1023;
	localparam int unsigned LZC_W  = 6;

	typedef struct packed {
		logic [WORD_W-1:0] bits;
		logic [1:0]        skind;
		logic [1:0]        wkind;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0] bits;
		logic [WORD_W-1:0] magnitude;
		logic              neg;
		logic              is_dbl;
		logic [1:0]        wkind;
		logic [LZC_W-1:0]  lzc;
		logic              mag_zero;
		logic              mag_top;
		logic [WORD_W-1:0] dmag;
		logic              d_ok;
	} front_t;

	typedef struct packed {
		logic [WORD_W-1:0] result;
		logic              exact;
		logic              req_valid;
	} res_t;

endpackage

### src/tnc_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
// Depends on nothing; the payload type is a parameter.
interface tnc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### src/tnc_front.sv
// Stage 1 of the converter: integer sign and magnitude, leading zero count,
// double unpacked to an integer magnitude. Depends on tnc_pkg.
module tnc_front
	import tnc_pkg::*;
(
	input  item_t  item,
	output front_t front
);
	logic signed [WORD_W-1:0] ival;
	logic [WORD_W-1:0]        mag;
	logic [LZC_W-1:0]         lz;
	logic [EXP_W-1:0]         dexp;
	logic [MANT_W-1:0]        dman;
	logic [WORD_W-1:0]        sig;
	logic [WORD_W-1:0]        dmag;
	logic                     d_ok;
	logic                     frac_zero;
	logic [EXP_W:0]           ue;

	always_comb begin
		if (item.skind == KIND_I32) begin
			ival = {{32{item.bits[31]}}, item.bits[31:0]};
		end else begin
			ival = item.bits;
		end
		mag = ival[WORD_W-1] ? (~ival + 64'd1) : ival;
		lz = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (mag[i]) begin
				lz = LZC_W'(WORD_W - 1 - i);
			end
		end

		// double to integer magnitude
		dexp = item.bits[WORD_W-2 -: EXP_W];
		dman = item.bits[MANT_W-1:0];
		sig  = {11'd0, (dexp != '0), dman};
		ue   = {1'b0, dexp} - (EXP_W+1)'(BIAS);
		frac_zero = 1'b0;
		dmag = '0;
		d_ok = 1'b0;
		if (dexp == '0) begin
			d_ok = (dman == '0);
		end else if (dexp < EXP_W'(BIAS)) begin
			d_ok = 1'b0;
		end else if (ue <= (EXP_W+1)'(MANT_W)) begin
			frac_zero = ((sig & ~({WORD_W{1'b1}} << (MANT_W - ue[5:0]))) == '0);
			dmag = sig >> (MANT_W - ue[5:0]);
			d_ok = frac_zero;
		end else if (ue < (EXP_W+1)'(63)) begin
			dmag = sig << (ue[5:0] - 6'(MANT_W));
			d_ok = 1'b1;
		end else if (ue == (EXP_W+1)'(63)) begin
			d_ok = item.bits[WORD_W-1] && (dman == '0);
			dmag = {1'b1, 63'd0};
		end

		front.bits      = (item.skind == KIND_F64) ? item.bits : ival;
		front.magnitude = mag;
		front.neg       = ival[WORD_W-1];
		front.is_dbl    = (item.skind == KIND_F64);
		front.wkind     = item.wkind;
		front.lzc       = lz;
		front.mag_zero  = (mag == '0);
		front.mag_top   = mag[WORD_W-1];
		front.dmag      = dmag;
		front.d_ok      = d_ok;
	end
endmodule

### src/tnc_back.sv
// Stage 2 of the converter: integer to float rounding, signed double to
// integer, range check and result select. Depends on tnc_pkg.
module tnc_back
	import tnc_pkg::*;
(
	input  front_t front,
	output res_t   res
);
	logic [WORD_W-1:0]      norm;
	logic [MANT_W:0]        keep;
	logic                   guard;
	logic                   sticky;
	logic                   rnd_up;
	logic [MANT_W+1:0]      rounded;
	logic [EXP_W-1:0]       e_out;
	logic [WORD_W-1:0]      i2d;
	logic                   i2d_exact;
	logic [WORD_W-1:0]      dint;
	logic                   fits32;
	logic signed [WORD_W-1:0] sint;

	always_comb begin
		// integer to double
		norm      = front.magnitude << front.lzc;
		keep      = norm[WORD_W-1 -: MANT_W+1];
		guard     = norm[WORD_W-MANT_W-2];
		sticky    = |norm[WORD_W-MANT_W-3:0];
		rnd_up    = guard && (sticky || keep[0]);
		rounded   = {1'b0, keep} + (MANT_W+2)'(rnd_up);
		e_out     = EXP_W'(BIAS + WORD_W - 1) - EXP_W'(front.lzc) + EXP_W'(rounded[MANT_W+1]);
		if (front.mag_zero) begin
			i2d = '0;
		end else if (rounded[MANT_W+1]) begin
			i2d = {front.neg, e_out, MANT_W'(0)};
		end else begin
			i2d = {front.neg, e_out, rounded[MANT_W-1:0]};
		end
		i2d_exact = !(guard || sticky) && !(front.mag_top && !front.neg);

		// double to integer
		if (!front.d_ok) begin
			dint = '0;
		end else if (front.bits[WORD_W-1]) begin
			dint = ~front.dmag + 64'd1;
		end else begin
			dint = front.dmag;
		end

		sint   = front.is_dbl ? dint : front.bits;
		fits32 = (sint >= -64'sd2147483648) && (sint <= 64'sd2147483647);

		res.req_valid = 1'b1;
		unique case (front.wkind)
			KIND_I32: begin
				res.result = {32'd0, sint[31:0]};
				res.exact  = (front.is_dbl ? front.d_ok : 1'b1) && fits32;
			end
			KIND_I64: begin
				res.result = sint;
				res.exact  = front.is_dbl ? front.d_ok : 1'b1;
			end
			KIND_F64: begin
				res.result = front.is_dbl ? front.bits : i2d;
				res.exact  = front.is_dbl ? 1'b1 : i2d_exact;
			end
			default: begin
				res.result    = '0;
				res.exact     = 1'b0;
				res.req_valid = 1'b0;
			end
		endcase
	end
endmodule

### src/tagged_number_conversion_core.sv
// Tagged number conversion core: int32/int64/double conversion with exact flag.
// One transaction per cycle while out_ch.ready is high; a stall holds a full stage only
// if all later stages are full. Three register stages: input, front end, result.
// Asynchronous active-low reset clears the stage valid bits only.
// Depends on tnc_pkg, tnc_stream_if, tnc_front, tnc_back.
module tagged_number_conversion_core
	import tnc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	tnc_stream_if.sink   in_ch,
	tnc_stream_if.source out_ch
);
	item_t  item_s1;
	front_t front_c;
	front_t front_s2;
	res_t   res_c;
	res_t   res_s3;
	logic   v_s1, v_s2, v_s3;
	logic   adv3, adv2, adv1;

	assign adv3 = !v_s3 || out_ch.ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ch.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_ch.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) item_s1 <= in_ch.payload;
		if (adv2) front_s2 <= front_c;
		if (adv3) res_s3 <= res_c;
	end

	tnc_front u_front (.item(item_s1), .front(front_c));
	tnc_back  u_back  (.front(front_s2), .res(res_c));

	assign out_ch.valid   = v_s3;
	assign out_ch.payload = res_s3;
endmodule
